FILE: hdl/aes128_pkg.sv
// Package: AES-128 types, S-box functions and GF(2^8) helpers.
`timescale 1ns / 1ps
package aes128_pkg;

	localparam int NumRoundsDefault = 10;
	localparam int KeyWidth = 64;
	localparam int AddrWidth = 4;

	localparam logic [AddrWidth-1:0] RegKeyHigh = 4'h0;
	localparam logic [AddrWidth-1:0] RegKeyLow  = 4'h8;

	localparam logic FuncEncrypt = 1'b0;
	localparam logic FuncDecrypt = 1'b1;

	typedef logic [127:0] block_t;

	// control from sequencer to round unit
	typedef struct packed {
		logic load;      // take input block, xor first round key
		logic step;      // run one round
		logic decrypt;
		logic last;      // final round: no mix
	} round_ctl_t;

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		sbox_fwd = t[a];
	endfunction

	function automatic logic [7:0] sbox_inv(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		sbox_inv = t[a];
	endfunction

	// byte i of a block sits in bits 127-8i .. 120-8i
	function automatic logic [7:0] get_byte(input block_t b, input int i);
		get_byte = b[127-8*i -: 8];
	endfunction

endpackage

FILE: hdl/aes128_key_sched.sv
// Key schedule: one round key per cycle into a 22x64 store.
`timescale 1ns / 1ps
module aes128_key_sched
	import aes128_pkg::*;
#(
	parameter int NUM_ROUNDS = NumRoundsDefault,
	localparam int RW = $clog2(NUM_ROUNDS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  block_t        cipher_key,
	input  logic [RW-1:0] rd_round,
	output block_t        rd_key,
	output logic          busy
);

	logic [63:0]   store_hi [NUM_ROUNDS+1];
	logic [63:0]   store_lo [NUM_ROUNDS+1];
	block_t        key_q;
	logic [7:0]    rcon_q;
	logic [RW-1:0] cnt_q;
	logic          busy_q;
	block_t        next_key;
	logic [31:0]   w0, w1, w2, w3, t;
	block_t        wr_key;

	always_comb begin
		t = {sbox_fwd(get_byte(key_q, 13)) ^ rcon_q, sbox_fwd(get_byte(key_q, 14)),
			sbox_fwd(get_byte(key_q, 15)), sbox_fwd(get_byte(key_q, 12))};
		w0 = key_q[127:96] ^ t;
		w1 = key_q[95:64] ^ w0;
		w2 = key_q[63:32] ^ w1;
		w3 = key_q[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
		wr_key = start ? cipher_key : next_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= RW'(1);
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			rcon_q <= xtime(rcon_q);
			cnt_q  <= cnt_q + RW'(1);
			if (cnt_q == RW'(NUM_ROUNDS)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start || busy_q) key_q <= wr_key;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			store_hi[0] <= cipher_key[127:64];
			store_lo[0] <= cipher_key[63:0];
		end else if (busy_q) begin
			store_hi[cnt_q] <= next_key[127:64];
			store_lo[cnt_q] <= next_key[63:0];
		end
	end

	// unregistered read: small store, one address
	assign rd_key = {store_hi[rd_round], store_lo[rd_round]};
	assign busy   = busy_q;

endmodule

FILE: hdl/aes128_round.sv
// Shared round unit: one encrypt or decrypt round per cycle while step is set.
`timescale 1ns / 1ps
module aes128_round
	import aes128_pkg::*;
(
	input  logic       clk,
	input  round_ctl_t ctl,
	input  block_t     din,
	input  block_t     rkey,
	output block_t     state
);

	block_t state_q;
	block_t sub, mixed, ark, nxt;

	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] r [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		for (int i = 0; i < 4; i++) begin
			a[i] = c[31-8*i -: 8];
			x2[i] = xtime(a[i]);
			x4[i] = xtime(x2[i]);
			x8[i] = xtime(x4[i]);
		end
		for (int i = 0; i < 4; i++) begin
			if (!inv)
				r[i] = x2[i] ^ x2[(i+1)%4] ^ a[(i+1)%4] ^ a[(i+2)%4] ^ a[(i+3)%4];
			else
				r[i] = (x8[i] ^ x4[i] ^ x2[i])
					^ (x8[(i+1)%4] ^ x2[(i+1)%4] ^ a[(i+1)%4])
					^ (x8[(i+2)%4] ^ x4[(i+2)%4] ^ a[(i+2)%4])
					^ (x8[(i+3)%4] ^ a[(i+3)%4]);
		end
		mix_col = {r[0], r[1], r[2], r[3]};
	endfunction

	always_comb begin
		sub = '0;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				if (!ctl.decrypt)
					sub[127-8*(4*c+i) -: 8] =
						sbox_fwd(get_byte(state_q, 4*((c+i)%4)+i));
				else
					sub[127-8*(4*((c+i)%4)+i) -: 8] =
						sbox_inv(get_byte(state_q, 4*c+i));
			end
		end
		// encrypt: mix then key; decrypt: key then mix
		mixed = '0;
		ark = '0;
		if (!ctl.decrypt) begin
			for (int c = 0; c < 4; c++)
				mixed[127-32*c -: 32] = mix_col(sub[127-32*c -: 32], 1'b0);
			nxt = (ctl.last ? sub : mixed) ^ rkey;
		end else begin
			ark = sub ^ rkey;
			for (int c = 0; c < 4; c++)
				mixed[127-32*c -: 32] = mix_col(ark[127-32*c -: 32], 1'b1);
			nxt = ctl.last ? ark : mixed;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)      state_q <= din ^ rkey;
		else if (ctl.step) state_q <= nxt;
	end

	assign state = state_q;

endmodule

FILE: hdl/aes128_block_cipher.sv
// Top level: AES-128 with APB key registers and iterative round unit.
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, block_high/low, func | block in
//  out     | out_valid, out_stall, result_high/low    | word out
//  cfg     | psel penable pwrite paddr pwdata prdata   | key registers
//
// Each word goes through load, ten rounds through one round unit, then into
// the result register before the next word is accepted. After a key write the
// first word first waits for key expansion. While an earlier result still
// waits in the result register, the finished block holds in the round unit.
// Reset clears control; the round key store has no reset.
`timescale 1ns / 1ps
module aes128_block_cipher
	import aes128_pkg::*;
#(
	parameter int NUM_ROUNDS = NumRoundsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [63:0]          block_high,
	input  logic [63:0]          block_low,
	input  logic                 func,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          result_high,
	output logic [63:0]          result_low
);

	localparam int RW = $clog2(NUM_ROUNDS + 1);
	localparam logic [2:0] StIdle = 3'd0, StExp = 3'd1, StLoad = 3'd2,
		StRun = 3'd3, StOut = 3'd4;

	logic [2:0]    st_q;
	logic [63:0]   key_high_q, key_low_q;
	logic          keys_ready_q;
	block_t        blk_q;
	logic          dec_q;
	logic [RW-1:0] rnd_q;
	logic [RW-1:0] rd_round;
	block_t        rd_key, state;
	logic          ks_start, ks_busy;
	round_ctl_t    ctl;
	logic          wr_en;
	logic          res_load;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (wr_en) begin
			if (paddr == RegKeyHigh) key_high_q <= pwdata;
			if (paddr == RegKeyLow)  key_low_q  <= pwdata;
		end
	end

	always_comb begin
		if (paddr == RegKeyHigh)     prdata = key_high_q;
		else if (paddr == RegKeyLow) prdata = key_low_q;
		else                         prdata = '0;
	end

	assign in_stall = (st_q != StIdle);
	assign ks_start = (st_q == StIdle) && in_valid && !keys_ready_q;
	// result register free, or emptied at this edge
	assign res_load = (st_q == StOut) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= StIdle;
			keys_ready_q <= 1'b0;
			rnd_q        <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (wr_en && (paddr == RegKeyHigh || paddr == RegKeyLow))
				keys_ready_q <= 1'b0;
			unique case (st_q)
				StIdle: if (in_valid) begin
					if (keys_ready_q) st_q <= StLoad;
					else begin
						st_q <= StExp;
						keys_ready_q <= 1'b1;
					end
				end
				StExp:  if (!ks_busy) st_q <= StLoad;
				StLoad: begin
					st_q  <= StRun;
					rnd_q <= RW'(1);
				end
				StRun: begin
					rnd_q <= rnd_q + RW'(1);
					if (rnd_q == RW'(NUM_ROUNDS)) st_q <= StOut;
				end
				StOut: if (res_load) st_q <= StIdle;
				default: st_q <= StIdle;
			endcase
			if (res_load)                     out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == StIdle && in_valid) begin
			blk_q <= {block_high, block_low};
			dec_q <= func;
		end
		if (res_load) begin
			result_high <= state[127:64];
			result_low  <= state[63:0];
		end
	end

	always_comb begin
		if (st_q == StLoad) rd_round = dec_q ? RW'(NUM_ROUNDS) : '0;
		else rd_round = dec_q ? RW'(NUM_ROUNDS) - rnd_q : rnd_q;
		ctl.load    = (st_q == StLoad);
		ctl.step    = (st_q == StRun);
		ctl.decrypt = (dec_q == FuncDecrypt);
		ctl.last    = (rnd_q == RW'(NUM_ROUNDS));
	end

	aes128_key_sched #(.NUM_ROUNDS(NUM_ROUNDS)) u_ks (
		.clk(clk), .arst_n(arst_n), .start(ks_start),
		.cipher_key({key_high_q, key_low_q}), .rd_round(rd_round),
		.rd_key(rd_key), .busy(ks_busy)
	);

	aes128_round u_round (
		.clk(clk), .ctl(ctl), .din(blk_q), .rkey(rd_key), .state(state)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StRun) |-> in_stall) else $error("accept while running");
	a_out_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == StOut)) else $error("stray result");
	a_ks_idle_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StRun || st_q == StLoad) |-> !ks_busy) else $error("key busy");

endmodule
